[rtl/der_tlv_stream_parser_assert.svh]
// assertion macros for the der tlv stream parser
// no dependencies; taken in by files that carry concurrent assertions
`ifndef DER_TLV_STREAM_PARSER_ASSERT_SVH
`define DER_TLV_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define DTSP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dtsp assertion failed");
// condition must never be true outside reset
`define DTSP_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dtsp forbidden condition seen");
`else
`define DTSP_ASSERT(label, clk, rst_n, prop)
`define DTSP_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/dtsp_pkg.sv]
// shared types and constants of the der tlv stream parser
// no dependencies; used by the result interface and the top level
package dtsp_pkg;

	localparam int MAX_LENGTH_BYTES = 7;
	localparam int LEN_W = 31;
	localparam int LBC_W = 3;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN_FIRST,
		PH_LEN_MORE,
		PH_VALUE,
		PH_IGNORE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_ZERO_TAG  = 2'd0,
		ERR_TOO_MANY  = 2'd1,
		ERR_OVERFLOW  = 2'd2,
		ERR_TRUNCATED = 2'd3
	} err_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       tag;
		logic [LEN_W-1:0] length;
		logic [7:0]       value_byte;
		logic             element_end;
		err_t             error_code;
	} result_t;

endpackage

[rtl/dtsp_byte_if.sv]
// input channel of the parser: one stream byte or an end of stream per item
// depends on nothing but the handshake convention valid and ready
interface dtsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

[rtl/dtsp_result_if.sv]
// output channel of the parser: one header, value byte or error per item
// depends on dtsp_pkg for the result field types
interface dtsp_result_if;
	import dtsp_pkg::*;

	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [7:0]       tag;
	logic [LEN_W-1:0] length;
	logic [7:0]       value_byte;
	logic             element_end;
	err_t             error_code;

	modport source (output valid, output kind, output tag, output length,
		output value_byte, output element_end, output error_code, input ready);
	modport sink (input valid, input kind, input tag, input length,
		input value_byte, input element_end, input error_code, output ready);
endinterface

[rtl/der_tlv_stream_parser.sv]
// der tlv stream parser: splits a byte stream into headers and value bytes
// depends on dtsp_pkg, dtsp_byte_if, dtsp_result_if and the assertion header
// a result is registered in the result register, or in the skid while that one is full and not taken
// throughput: one item per cycle while the skid is empty; the parse state updates in the accept cycle
// a two-entry output buffer (result register plus skid) keeps input open
// while one result waits; input stalls only when both entries are full
// reset clears the parse phase, counters and both output valid flags
`include "der_tlv_stream_parser_assert.svh"

module der_tlv_stream_parser (
	input logic           clk,
	input logic           arst_n,
	dtsp_byte_if.sink     stream,
	dtsp_result_if.source elements
);
	import dtsp_pkg::*;

	localparam logic [LEN_W-1:0] OVF_LIMIT = {8'd0, {(LEN_W-8){1'b1}}};
	localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_BYTES);

	phase_t           phase_q, phase_nxt;
	logic [7:0]       tag_q, tag_nxt;
	logic [LEN_W-1:0] accum_q, accum_nxt;
	logic [LBC_W-1:0] len_left_q, len_left_nxt;
	logic [LEN_W-1:0] val_left_q, val_left_nxt;

	result_t          res;
	logic             has_res;
	logic             in_fire;
	logic             res_fire;
	logic             out_take;

	result_t          out_q, skid_q;
	logic             out_vld_q, skid_vld_q;

	logic [7:0]       b;
	logic [LEN_W-1:0] hdr_len;
	logic             do_header;
	logic [LEN_W-1:0] val_dec;

	assign b = stream.data_byte;
	assign stream.ready = !skid_vld_q;
	assign in_fire = stream.valid && stream.ready;
	assign res_fire = in_fire && has_res;
	assign out_take = out_vld_q && elements.ready;
	assign val_dec = val_left_q - LEN_W'(1);

	// parse step for one item
	always_comb begin
		phase_nxt = phase_q;
		tag_nxt = tag_q;
		accum_nxt = accum_q;
		len_left_nxt = len_left_q;
		val_left_nxt = val_left_q;
		has_res = 1'b0;
		do_header = 1'b0;
		hdr_len = '0;
		res.kind = KIND_HEADER;
		res.length = '0;
		res.value_byte = '0;
		res.element_end = 1'b0;
		res.error_code = ERR_ZERO_TAG;
		if (stream.stream_end) begin
			phase_nxt = PH_TAG;
			if (phase_q != PH_TAG && phase_q != PH_IGNORE) begin
				has_res = 1'b1;
				res.kind = KIND_ERROR;
				res.error_code = ERR_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					tag_nxt = b;
					accum_nxt = '0;
					len_left_nxt = '0;
					val_left_nxt = '0;
					if (b == 8'd0) begin
						phase_nxt = PH_IGNORE;
						has_res = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_ZERO_TAG;
					end else begin
						phase_nxt = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					if (b[7]) begin
						if (b[6:0] > MAX_N) begin
							phase_nxt = PH_IGNORE;
							has_res = 1'b1;
							res.kind = KIND_ERROR;
							res.error_code = ERR_TOO_MANY;
						end else if (b[6:0] == 7'd0) begin
							accum_nxt = '0;
							do_header = 1'b1;
							hdr_len = '0;
						end else begin
							accum_nxt = '0;
							len_left_nxt = b[LBC_W-1:0];
							phase_nxt = PH_LEN_MORE;
						end
					end else begin
						accum_nxt = LEN_W'(b);
						do_header = 1'b1;
						hdr_len = LEN_W'(b);
					end
				end
				PH_LEN_MORE: begin
					if (accum_q > OVF_LIMIT) begin
						phase_nxt = PH_IGNORE;
						has_res = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_OVERFLOW;
					end else begin
						accum_nxt = {accum_q[LEN_W-9:0], b};
						len_left_nxt = len_left_q - LBC_W'(1);
						if (len_left_q == LBC_W'(1)) begin
							do_header = 1'b1;
							hdr_len = {accum_q[LEN_W-9:0], b};
						end
					end
				end
				PH_VALUE: begin
					val_left_nxt = val_dec;
					has_res = 1'b1;
					res.kind = KIND_VALUE;
					res.length = accum_q;
					res.value_byte = b;
					if (val_dec == '0) begin
						phase_nxt = PH_TAG;
						res.element_end = 1'b1;
					end
				end
				default: begin
					phase_nxt = PH_IGNORE;
				end
			endcase
			// header once the length is complete
			if (do_header) begin
				has_res = 1'b1;
				res.kind = KIND_HEADER;
				res.length = hdr_len;
				if (hdr_len == '0) begin
					phase_nxt = PH_TAG;
					res.element_end = 1'b1;
				end else begin
					phase_nxt = PH_VALUE;
					val_left_nxt = hdr_len;
				end
			end
		end
		res.tag = tag_nxt;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q <= '0;
			accum_q <= '0;
			len_left_q <= '0;
			val_left_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_nxt;
			tag_q <= tag_nxt;
			accum_q <= accum_nxt;
			len_left_q <= len_left_nxt;
			val_left_q <= val_left_nxt;
		end
	end

	// output buffer valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (res_fire) begin
			if (!out_vld_q || out_take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (res_fire) begin
			if (!out_vld_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_take && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

	assign elements.valid = out_vld_q;
	assign elements.kind = out_q.kind;
	assign elements.tag = out_q.tag;
	assign elements.length = out_q.length;
	assign elements.value_byte = out_q.value_byte;
	assign elements.element_end = out_q.element_end;
	assign elements.error_code = out_q.error_code;

	// checks
	`DTSP_NEVER(a_skid_without_out, clk, arst_n, skid_vld_q && !out_vld_q)
	`DTSP_NEVER(a_len_more_count, clk, arst_n, phase_q == PH_LEN_MORE && len_left_q == '0)
	`DTSP_NEVER(a_value_count, clk, arst_n, phase_q == PH_VALUE && val_left_q == '0)
	`DTSP_ASSERT(a_error_fields, clk, arst_n,
		(out_vld_q && out_q.kind == KIND_ERROR) |-> (out_q.length == '0 && !out_q.element_end))
	`DTSP_ASSERT(a_last_value_ends, clk, arst_n,
		(in_fire && !stream.stream_end && phase_q == PH_VALUE && val_left_q == LEN_W'(1))
		|=> (phase_q == PH_TAG))

endmodule
